/* hw/rtl/esd_pkg.sv */
// ----------------------------------------------------------------------------
// esd_pkg: escape sequence decoder shared types and constants
// Byte constants, decode modes, configuration indexes and the structs passed
// between the decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package esd_pkg;

  localparam int ByteWidth     = 8;
  localparam int AccWidth      = 10;
  localparam int CountWidth    = 2;
  localparam int FaultWidth    = 2;
  localparam int CfgIndexWidth = 2;

  // configuration register indexes
  localparam logic [CfgIndexWidth-1:0] CFG_ESCAPE  = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_QUOTE   = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_COMMENT = 2'd2;

  localparam logic [ByteWidth-1:0] EscapeReset  = 8'd33;
  localparam logic [ByteWidth-1:0] QuoteReset   = 8'd34;
  localparam logic [ByteWidth-1:0] CommentReset = 8'd35;

  // fault codes
  localparam logic [FaultWidth-1:0] FAULT_NONE      = 2'd0;
  localparam logic [FaultWidth-1:0] FAULT_UNKNOWN   = 2'd1;
  localparam logic [FaultWidth-1:0] FAULT_BAD_DIGIT = 2'd2;

  // named escape values
  localparam logic [ByteWidth-1:0] ChNewline   = 8'd10;
  localparam logic [ByteWidth-1:0] ChReturn    = 8'd13;
  localparam logic [ByteWidth-1:0] ChBackspace = 8'd8;
  localparam logic [ByteWidth-1:0] ChTab       = 8'd9;
  localparam logic [ByteWidth-1:0] ChFormfeed  = 8'd12;
  localparam logic [ByteWidth-1:0] ChNul       = 8'd0;

  localparam logic [CountWidth-1:0] HexDigits = 2'd2;
  localparam logic [CountWidth-1:0] OctDigits = 2'd2;
  localparam logic [CountWidth-1:0] DecDigits = 2'd3;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_ESC  = 3'd1,
    MODE_HEX  = 3'd2,
    MODE_OCT  = 3'd3,
    MODE_DEC  = 3'd4
  } esd_mode_t;

  typedef struct packed {
    logic [ByteWidth-1:0] escape_char;
    logic [ByteWidth-1:0] quote_char;
    logic [ByteWidth-1:0] comment_char;
  } esd_cfg_t;

  typedef struct packed {
    esd_mode_t             decode_mode;
    logic [CountWidth-1:0] digits_seen;
    logic [AccWidth-1:0]   accumulated_value;
  } esd_state_t;

  typedef struct packed {
    logic                  char_valid;
    logic [ByteWidth-1:0]  char_value;
    logic [FaultWidth-1:0] fault;
    logic                  string_done;
  } esd_result_t;

  localparam esd_state_t StateIdle = '{decode_mode: MODE_IDLE, digits_seen: '0,
                                       accumulated_value: '0};

  function automatic logic [ByteWidth-1:0] lower_ascii(input logic [ByteWidth-1:0] c);
    logic [ByteWidth-1:0] r;
    r = c;
    if (c >= "A" && c <= "Z") begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/esd_in_if.sv */
// ----------------------------------------------------------------------------
// esd_in_if: text byte channel
// Valid/ready channel carrying one string byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface esd_in_if;
  logic                           valid;
  logic                           ready;
  logic [esd_pkg::ByteWidth-1:0]  text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

`default_nettype wire

/* hw/rtl/esd_out_if.sv */
// ----------------------------------------------------------------------------
// esd_out_if: decoded character channel
// Valid/ready channel carrying one decode result per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface esd_out_if;
  logic                            valid;
  logic                            ready;
  logic                            char_valid;
  logic [esd_pkg::ByteWidth-1:0]   char_value;
  logic [esd_pkg::FaultWidth-1:0]  fault;
  logic                            string_done;

  modport source (output valid, output char_valid, output char_value, output fault,
                  output string_done, input ready);
  modport sink   (input valid, input char_valid, input char_value, input fault,
                  input string_done, output ready);
endinterface

`default_nettype wire

/* hw/rtl/esd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// esd_cfg_regs: configuration registers
// Holds the escape, quote and comment bytes, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module esd_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [esd_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  wire logic [esd_pkg::ByteWidth-1:0]      cfg_data,
  output esd_pkg::esd_cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.escape_char  <= esd_pkg::EscapeReset;
      cfg.quote_char   <= esd_pkg::QuoteReset;
      cfg.comment_char <= esd_pkg::CommentReset;
    end else if (cfg_we) begin
      case (cfg_index)
        esd_pkg::CFG_ESCAPE:  cfg.escape_char  <= cfg_data;
        esd_pkg::CFG_QUOTE:   cfg.quote_char   <= cfg_data;
        esd_pkg::CFG_COMMENT: cfg.comment_char <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/esd_decode.sv */
// ----------------------------------------------------------------------------
// esd_decode: one-byte decode step
// Combinational next state and result for one text byte.
// ----------------------------------------------------------------------------
`default_nettype none

module esd_decode (
  input  esd_pkg::esd_cfg_t                   cfg,
  input  esd_pkg::esd_state_t                 state,
  input  wire logic [esd_pkg::ByteWidth-1:0]  text_byte,
  output esd_pkg::esd_state_t                 state_next,
  output esd_pkg::esd_result_t                result
);

  logic [esd_pkg::ByteWidth-1:0]  low;
  logic [esd_pkg::ByteWidth-1:0]  value;
  logic [esd_pkg::FaultWidth-1:0] fault;
  logic                           done;
  logic                           digit_ok;
  logic [3:0]                     digit;
  logic [esd_pkg::AccWidth-1:0]   acc_scaled;
  logic [esd_pkg::AccWidth-1:0]   acc_new;
  logic [esd_pkg::CountWidth-1:0] count_new;
  logic [esd_pkg::CountWidth-1:0] limit;

  assign low = esd_pkg::lower_ascii(text_byte);

  // digit of the current base, and accumulator times base
  always_comb begin
    digit_ok   = 1'b0;
    digit      = '0;
    acc_scaled = '0;
    limit      = esd_pkg::HexDigits;
    case (state.decode_mode)
      esd_pkg::MODE_HEX: begin
        acc_scaled = {state.accumulated_value[esd_pkg::AccWidth-5:0], 4'b0};
        if (text_byte >= "0" && text_byte <= "9") begin
          digit_ok = 1'b1;
          digit    = text_byte[3:0];
        end else if (low >= "a" && low <= "f") begin
          digit_ok = 1'b1;
          digit    = 4'(low - ("a" - 8'd10));
        end
      end
      esd_pkg::MODE_OCT: begin
        limit      = esd_pkg::OctDigits;
        acc_scaled = {state.accumulated_value[esd_pkg::AccWidth-4:0], 3'b0};
        if (text_byte >= "0" && text_byte <= "7") begin
          digit_ok = 1'b1;
          digit    = text_byte[3:0];
        end
      end
      esd_pkg::MODE_DEC: begin
        limit      = esd_pkg::DecDigits;
        acc_scaled = {state.accumulated_value[esd_pkg::AccWidth-4:0], 3'b0}
                   + {state.accumulated_value[esd_pkg::AccWidth-2:0], 1'b0};
        if (text_byte >= "0" && text_byte <= "9") begin
          digit_ok = 1'b1;
          digit    = text_byte[3:0];
        end
      end
      default: ;
    endcase
  end

  assign acc_new   = acc_scaled + esd_pkg::AccWidth'(digit);
  assign count_new = state.digits_seen + 2'd1;

  always_comb begin
    state_next = esd_pkg::StateIdle;
    value      = esd_pkg::ChNul;
    fault      = esd_pkg::FAULT_NONE;
    done       = 1'b0;
    case (state.decode_mode)
      esd_pkg::MODE_ESC: begin
        done = (text_byte == esd_pkg::ChNul);
        if (low == cfg.quote_char || low == cfg.escape_char || low == cfg.comment_char) begin
          value = low;
        end else if (low == "n") begin
          value = esd_pkg::ChNewline;
        end else if (low == "r") begin
          value = esd_pkg::ChReturn;
        end else if (low == "b") begin
          value = esd_pkg::ChBackspace;
        end else if (low == "t") begin
          value = esd_pkg::ChTab;
        end else if (low == "f") begin
          value = esd_pkg::ChFormfeed;
        end else if (low == "{" || low == "}" || low == "[" || low == "]" ||
                     low == "=" || low == " ") begin
          value = low;
        end else if (low == "x") begin
          state_next.decode_mode = esd_pkg::MODE_HEX;
        end else if (low >= "0" && low <= "7") begin
          state_next.decode_mode       = esd_pkg::MODE_OCT;
          state_next.accumulated_value = esd_pkg::AccWidth'(low[2:0]);
        end else if (low == "d") begin
          state_next.decode_mode = esd_pkg::MODE_DEC;
        end else begin
          fault = esd_pkg::FAULT_UNKNOWN;
        end
      end
      esd_pkg::MODE_HEX, esd_pkg::MODE_OCT, esd_pkg::MODE_DEC: begin
        if (text_byte == esd_pkg::ChNul) begin
          // terminator flushes the pending value
          value = state.accumulated_value[esd_pkg::ByteWidth-1:0];
          done  = 1'b1;
        end else if (!digit_ok) begin
          fault = esd_pkg::FAULT_BAD_DIGIT;
        end else if (count_new >= limit) begin
          value = acc_new[esd_pkg::ByteWidth-1:0];
        end else begin
          state_next.decode_mode       = state.decode_mode;
          state_next.digits_seen       = count_new;
          state_next.accumulated_value = acc_new;
        end
      end
      default: begin
        if (text_byte == esd_pkg::ChNul) begin
          done = 1'b1;
        end else if (text_byte == cfg.escape_char) begin
          state_next.decode_mode = esd_pkg::MODE_ESC;
        end else begin
          value = text_byte;
        end
      end
    endcase
  end

  assign result.char_valid  = (value != esd_pkg::ChNul);
  assign result.char_value  = value;
  assign result.fault       = fault;
  assign result.string_done = done;

endmodule

`default_nettype wire

/* hw/rtl/escape_sequence_decoder_top.sv */
// ----------------------------------------------------------------------------
// escape_sequence_decoder_top: streaming escape sequence decoder
// Decodes escape sequences in a byte string, one result per input byte.
// ----------------------------------------------------------------------------
// Usage:
//   text_in  : valid/ready channel, one string byte per item; 0 ends a string.
//   char_out : valid/ready channel, exactly one result per input item, with
//              char_valid/char_value (decoded byte), fault and string_done.
//   cfg_we/cfg_index/cfg_data : writes escape (0), quote (1) and comment (2)
//              bytes; write only while no item is in flight.
// Path: each byte is taken into the input register, then decoded into the
//   result register that drives char_out.
// Throughput: one item per cycle while char_out is taken; the decode state is
//   registered and feeds back, so consecutive bytes are taken back to back.
// Stall: when char_out is not taken, the result register holds; text_in.ready
//   drops at once if the input register holds a byte, otherwise the empty
//   input register takes one more byte first.
// Reset: registers return to escape 33, quote 34, comment 35; decoder idle,
//   both pipeline stages empty.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_sequence_decoder_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  esd_in_if.sink                                  text_in,
  esd_out_if.source                               char_out,
  input  wire logic                               cfg_we,
  input  wire logic [esd_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  wire logic [esd_pkg::ByteWidth-1:0]      cfg_data
);

  esd_pkg::esd_cfg_t    cfg;
  esd_pkg::esd_state_t  state;
  esd_pkg::esd_state_t  state_next;
  esd_pkg::esd_result_t dec_result;
  esd_pkg::esd_result_t out_result;

  logic                          in_valid;
  logic [esd_pkg::ByteWidth-1:0] in_byte;
  logic                          out_valid;
  logic                          out_advance;
  logic                          in_ready;

  esd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  esd_decode u_decode (
    .cfg        (cfg),
    .state      (state),
    .text_byte  (in_byte),
    .state_next (state_next),
    .result     (dec_result)
  );

  assign out_advance   = !out_valid || char_out.ready;
  assign in_ready      = !in_valid || out_advance;
  assign text_in.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= text_in.valid;
    end
    if (in_ready && text_in.valid) begin
      in_byte <= text_in.text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      state     <= esd_pkg::StateIdle;
    end else if (out_advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        state <= state_next;
      end
    end
    if (out_advance && in_valid) begin
      out_result <= dec_result;
    end
  end

  assign char_out.valid       = out_valid;
  assign char_out.char_valid  = out_result.char_valid;
  assign char_out.char_value  = out_result.char_value;
  assign char_out.fault       = out_result.fault;
  assign char_out.string_done = out_result.string_done;

  // a fault never comes with a character
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.fault != esd_pkg::FAULT_NONE |-> !out_result.char_valid)
    else $error("fault with emitted character");

  // emitted characters are never zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.char_valid |-> out_result.char_value != esd_pkg::ChNul)
    else $error("zero character emitted");

  // terminator always leaves the decoder idle
  assert property (@(posedge clk) disable iff (rst)
    out_advance && in_valid && dec_result.string_done
      |=> state.decode_mode == esd_pkg::MODE_IDLE)
    else $error("decoder not idle after terminator");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !char_out.ready |=> out_valid && $stable(out_result))
    else $error("stalled result changed");

endmodule

`default_nettype wire

/* verif/tb_escape_sequence_decoder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_escape_sequence_decoder_top: escape sequence decoder testbench
// Streams byte strings through the decoder under several escape, quote and
// comment settings, with random idling on both channels. Each decoded item is
// compared field by field against an in-bench model of the decode state.
// ----------------------------------------------------------------------------

module tb_escape_sequence_decoder_top;

  typedef logic [esd_pkg::ByteWidth-1:0] text_t;

  class esc_scoreboard;
    text_t                          esc_ch;
    text_t                          quote_ch;
    text_t                          comment_ch;
    esd_pkg::esd_mode_t             mode;
    logic [esd_pkg::CountWidth-1:0] ndigits;
    logic [esd_pkg::AccWidth-1:0]   acc;
    esd_pkg::esd_result_t           decoded_q[$];
    int                             errors;

    function new();
      esc_ch = esd_pkg::EscapeReset;
      quote_ch = esd_pkg::QuoteReset;
      comment_ch = esd_pkg::CommentReset;
      errors = 0;
      clear_escape();
    endfunction

    function void clear_escape();
      mode = esd_pkg::MODE_IDLE;
      ndigits = '0;
      acc = '0;
    endfunction

    function void set_register(logic [esd_pkg::CfgIndexWidth-1:0] idx, text_t v);
      case (idx)
        esd_pkg::CFG_ESCAPE:  esc_ch = v;
        esd_pkg::CFG_QUOTE:   quote_ch = v;
        esd_pkg::CFG_COMMENT: comment_ch = v;
        default: ;
      endcase
    endfunction

    function text_t fold_lower(text_t c);
      if (c >= "A" && c <= "Z") return c + 8'd32;
      return c;
    endfunction

    // -1 when c is not a digit of the base
    function int digit_value(text_t c, int base);
      int v;
      text_t u;
      if (c >= "0" && c <= "9") begin
        v = int'(c) - int'("0");
        return (v < base) ? v : -1;
      end
      if (base == 16) begin
        u = fold_lower(c);
        if (u >= "a" && u <= "f") return int'(u) - int'("a") + 10;
      end
      return -1;
    endfunction

    function void note_byte(text_t c);
      esd_pkg::esd_result_t r;
      text_t sel;
      text_t emit;
      int base;
      int limit;
      int d;
      r = '0;
      emit = '0;
      case (mode)
        esd_pkg::MODE_ESC: begin
          sel = fold_lower(c);
          clear_escape();
          // registers take priority over every built-in selector
          if (sel == quote_ch || sel == esc_ch || sel == comment_ch) emit = sel;
          else if (sel == "n") emit = esd_pkg::ChNewline;
          else if (sel == "r") emit = esd_pkg::ChReturn;
          else if (sel == "b") emit = esd_pkg::ChBackspace;
          else if (sel == "t") emit = esd_pkg::ChTab;
          else if (sel == "f") emit = esd_pkg::ChFormfeed;
          else if (sel == "{" || sel == "}" || sel == "[" || sel == "]" || sel == "=" ||
                   sel == " ") emit = sel;
          else if (sel == "x") mode = esd_pkg::MODE_HEX;
          else if (sel >= "0" && sel <= "7") begin
            mode = esd_pkg::MODE_OCT;
            acc = esd_pkg::AccWidth'(sel - "0");
          end else if (sel == "d") mode = esd_pkg::MODE_DEC;
          else r.fault = esd_pkg::FAULT_UNKNOWN;
          r.string_done = (c == esd_pkg::ChNul);
        end
        esd_pkg::MODE_HEX, esd_pkg::MODE_OCT, esd_pkg::MODE_DEC: begin
          base = (mode == esd_pkg::MODE_HEX) ? 16 : (mode == esd_pkg::MODE_OCT) ? 8 : 10;
          limit = (mode == esd_pkg::MODE_DEC) ? 3 : 2;
          if (c == esd_pkg::ChNul) begin
            emit = acc[esd_pkg::ByteWidth-1:0];
            r.string_done = 1'b1;
            clear_escape();
          end else begin
            d = digit_value(c, base);
            if (d < 0) begin
              r.fault = esd_pkg::FAULT_BAD_DIGIT;
              clear_escape();
            end else begin
              acc = esd_pkg::AccWidth'(int'(acc) * base + d);
              ndigits = ndigits + 1'b1;
              if (int'(ndigits) >= limit) begin
                emit = acc[esd_pkg::ByteWidth-1:0];
                clear_escape();
              end
            end
          end
        end
        default: begin
          clear_escape();
          if (c == esd_pkg::ChNul) r.string_done = 1'b1;
          else if (c == esc_ch) mode = esd_pkg::MODE_ESC;
          else emit = c;
        end
      endcase
      r.char_valid = (emit != '0);
      r.char_value = emit;
      decoded_q.push_back(r);
    endfunction

    task report(string what, text_t got, text_t want);
      if (errors < 40) $display("%0t ns mismatch %s: got %h want %h", $time, what, got, want);
      errors++;
    endtask

    task check_char(esd_pkg::esd_result_t got);
      esd_pkg::esd_result_t want;
      if (decoded_q.size() == 0) begin
        report("item with nothing pending", got.char_value, '0);
        return;
      end
      want = decoded_q.pop_front();
      if (got.char_valid !== want.char_valid)
        report("char_valid", text_t'(got.char_valid), text_t'(want.char_valid));
      if (got.char_value !== want.char_value)
        report("char_value", got.char_value, want.char_value);
      if (got.fault !== want.fault)
        report("fault", text_t'(got.fault), text_t'(want.fault));
      if (got.string_done !== want.string_done)
        report("string_done", text_t'(got.string_done), text_t'(want.string_done));
    endtask
  endclass

  // opening strings under the reset settings
  localparam text_t OpeningBytes [30] = '{
    8'hFF, "!", "N", "!", "{", "!", "x", "F", "f", "!", "7", "7", "7",
    "!", "d", "2", "5", "6", "!", "q", "!", "x", "g", "!", "d", "7", 8'h00,
    "!", 8'h00, 8'h00
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                              cfg_we;
  logic [esd_pkg::CfgIndexWidth-1:0] cfg_index;
  text_t                             cfg_data;

  esd_in_if  text_in ();
  esd_out_if char_out ();

  esc_scoreboard sb;
  bit quiet_run = 1'b0;
  int gap_odds = 6;
  int stall_odds = 6;
  int sent_count = 0;

  escape_sequence_decoder_top u_top (
    .clk       (clk),
    .rst       (rst),
    .text_in   (text_in),
    .char_out  (char_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin : monitor
    esd_pkg::esd_result_t got;
    if (!rst) begin
      if (text_in.valid && text_in.ready) sb.note_byte(text_in.text_byte);
      if (char_out.valid && char_out.ready) begin
        got.char_valid = char_out.char_valid;
        got.char_value = char_out.char_value;
        got.fault = char_out.fault;
        got.string_done = char_out.string_done;
        sb.check_char(got);
      end
    end
  end

  // receiver: stall bursts between runs of ready
  initial begin : receiver
    int run;
    char_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (quiet_run || $urandom_range(0, stall_odds) != 0) begin
        char_out.ready <= 1'b1;
        run = $urandom_range(1, 20);
      end else begin
        char_out.ready <= 1'b0;
        run = $urandom_range(1, 14);
      end
      repeat (run - 1) @(posedge clk);
    end
  end

  task automatic send_byte(input text_t b);
    int gap;
    gap = 0;
    if (!quiet_run && $urandom_range(0, gap_odds) == 0) gap = $urandom_range(1, 14);
    if (gap != 0) begin
      text_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_in.valid <= 1'b1;
    text_in.text_byte <= b;
    @(posedge clk);
    while (!text_in.ready) @(posedge clk);
    sent_count++;
  endtask

  // digits of a numeric escape; sometimes cut short by a terminator or a bad digit
  task automatic send_digits(input int base, input int count);
    int n;
    int v;
    int how;
    text_t ch;
    n = count;
    how = $urandom_range(0, 9);
    if (how <= 1) n = $urandom_range(0, count - 1);
    for (int i = 0; i < n; i++) begin
      v = $urandom_range(0, base - 1);
      if (v < 10) ch = text_t'("0" + v);
      else ch = text_t'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
      send_byte(ch);
    end
    if (how == 0) send_byte(esd_pkg::ChNul);
    if (how == 1) begin
      do ch = text_t'($urandom_range(1, 255)); while (sb.digit_value(ch, base) >= 0);
      send_byte(ch);
    end
  endtask

  task automatic send_token();
    int pick;
    text_t sel;
    string named_codes;
    string punct;
    named_codes = "nrbtf";
    punct = "{}[]= ";
    pick = $urandom_range(0, 99);
    if (pick < 32) begin
      send_byte(text_t'($urandom_range(0, 255)));
    end else if (pick < 38) begin
      send_byte(esd_pkg::ChNul);
    end else begin
      send_byte(sb.esc_ch);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        sel = named_codes[$urandom_range(0, 4)];
        if ($urandom_range(0, 1)) sel = sel - 8'd32;
        send_byte(sel);
      end else if (pick < 25) begin
        send_byte(punct[$urandom_range(0, 5)]);
      end else if (pick < 37) begin
        case ($urandom_range(0, 2))
          0: sel = sb.esc_ch;
          1: sel = sb.quote_ch;
          default: sel = sb.comment_ch;
        endcase
        if (sel >= "a" && sel <= "z" && $urandom_range(0, 1)) sel = sel - 8'd32;
        send_byte(sel);
      end else if (pick < 52) begin
        send_byte($urandom_range(0, 1) ? "x" : "X");
        send_digits(16, 2);
      end else if (pick < 67) begin
        send_byte(text_t'("0" + $urandom_range(0, 7)));
        send_digits(8, 2);
      end else if (pick < 82) begin
        send_byte($urandom_range(0, 1) ? "d" : "D");
        send_digits(10, 3);
      end else if (pick < 90) begin
        send_byte(esd_pkg::ChNul);
      end else begin
        send_byte(text_t'($urandom_range(0, 255)));
      end
    end
  endtask

  // lets every pending item come out with the sender held off
  task automatic drain_results();
    text_in.valid <= 1'b0;
    @(posedge clk);
    while (sb.decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [esd_pkg::CfgIndexWidth-1:0] idx, input text_t v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, v);
    @(posedge clk);
  endtask

  task automatic run_phase(input text_t esc, input text_t quo, input text_t com,
                           input int items);
    int target;
    write_reg(esd_pkg::CFG_ESCAPE, esc);
    write_reg(esd_pkg::CFG_QUOTE, quo);
    write_reg(esd_pkg::CFG_COMMENT, com);
    gap_odds = $urandom_range(2, 12);
    stall_odds = $urandom_range(2, 12);
    target = sent_count + items;
    while (sent_count < target) send_token();
    drain_results();
  endtask

  initial begin
    sb = new();
    text_in.valid <= 1'b0;
    text_in.text_byte <= '0;
    cfg_we <= 1'b0;
    cfg_index <= esd_pkg::CFG_ESCAPE;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (OpeningBytes[i]) send_byte(OpeningBytes[i]);
    drain_results();

    run_phase(esd_pkg::EscapeReset, esd_pkg::QuoteReset, esd_pkg::CommentReset, 100);
    run_phase(8'hFF, 8'h00, "x", 80);
    run_phase("\\", "n", "A", 80);
    // escape byte 0 is always taken as a terminator first
    run_phase(8'h00, "]", 8'hFF, 30);
    run_phase("E", 8'hFF, 8'h00, 80);
    run_phase(" ", "{", "7", 80);
    quiet_run = 1'b1;
    run_phase(esd_pkg::EscapeReset, esd_pkg::QuoteReset, esd_pkg::CommentReset, 70);

    if (sb.errors == 0 && sb.decoded_q.size() == 0) begin
      $display("PASS escape_sequence_decoder_top");
    end else begin
      $display("FAIL escape_sequence_decoder_top");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAIL escape_sequence_decoder_top");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/esd_pkg.sv
hw/rtl/esd_in_if.sv
hw/rtl/esd_out_if.sv
hw/rtl/esd_cfg_regs.sv
hw/rtl/esd_decode.sv
hw/rtl/escape_sequence_decoder_top.sv
verif/tb_escape_sequence_decoder_top.sv
